FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define A64D_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// implication checked at the following edge
`define A64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// implication with a delayed consequent
`define A64D_ASSERT_LATER2(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error("%m: check failed");

`endif

FILE: sv/a64d_pkg.sv
// types and mnemonic codes of the a64 subset decoder
package a64d_pkg;

    localparam int ADDR_W = 64;
    localparam int WORD_W = 32;
    localparam int IMM_W  = 33;

    localparam logic [5:0] MN_NONE  = 6'd0;
    localparam logic [5:0] MN_LDRB  = 6'd1;
    localparam logic [5:0] MN_LDRH  = 6'd2;
    localparam logic [5:0] MN_LDR   = 6'd3;
    localparam logic [5:0] MN_LDRSW = 6'd4;
    localparam logic [5:0] MN_STRB  = 6'd5;
    localparam logic [5:0] MN_STRH  = 6'd6;
    localparam logic [5:0] MN_STR   = 6'd7;
    localparam logic [5:0] MN_B     = 6'd8;
    localparam logic [5:0] MN_BL    = 6'd9;
    localparam logic [5:0] MN_CBZ   = 6'd10;
    localparam logic [5:0] MN_CBNZ  = 6'd11;
    localparam logic [5:0] MN_TBZ   = 6'd12;
    localparam logic [5:0] MN_TBNZ  = 6'd13;
    localparam logic [5:0] MN_BR    = 6'd14;
    localparam logic [5:0] MN_BLR   = 6'd15;
    localparam logic [5:0] MN_RET   = 6'd16;
    localparam logic [5:0] MN_NOP   = 6'd17;
    localparam logic [5:0] MN_HLT   = 6'd18;
    localparam logic [5:0] MN_ADD   = 6'd19;
    localparam logic [5:0] MN_ADDS  = 6'd20;
    localparam logic [5:0] MN_SUB   = 6'd21;
    localparam logic [5:0] MN_SUBS  = 6'd22;
    localparam logic [5:0] MN_CMN   = 6'd23;
    localparam logic [5:0] MN_CMP   = 6'd24;
    localparam logic [5:0] MN_MOVZ  = 6'd25;
    localparam logic [5:0] MN_MOVN  = 6'd26;
    localparam logic [5:0] MN_MOVK  = 6'd27;
    localparam logic [5:0] MN_ADR   = 6'd28;
    localparam logic [5:0] MN_ADRP  = 6'd29;
    localparam logic [5:0] MN_AND   = 6'd30;
    localparam logic [5:0] MN_MOV   = 6'd36;
    localparam logic [5:0] MN_LDP   = 6'd37;
    localparam logic [5:0] MN_STP   = 6'd38;
    localparam logic [5:0] MN_CSEL  = 6'd39;
    localparam logic [5:0] MN_CSINC = 6'd40;
    localparam logic [5:0] MN_CSET  = 6'd41;
    localparam logic [5:0] MN_ADC   = 6'd42;
    localparam logic [5:0] MN_MUL   = 6'd46;
    localparam logic [5:0] MN_MADD  = 6'd47;
    localparam logic [5:0] MN_MSUB  = 6'd48;
    localparam logic [5:0] MN_NEG   = 6'd49;
    localparam logic [5:0] MN_REV16 = 6'd50;
    localparam logic [5:0] MN_REV32 = 6'd51;
    localparam logic [5:0] MN_REV   = 6'd52;
    localparam logic [5:0] MN_CLZ   = 6'd53;
    localparam logic [5:0] MN_CLS   = 6'd54;
    localparam logic [5:0] MN_RBIT  = 6'd55;
    localparam logic [5:0] MN_LAST  = MN_RBIT;

    localparam logic [4:0] REG_ZR = 5'd31;

    // decoded operand fields of one word
    typedef struct packed {
        logic [5:0]       mn;
        logic [4:0]       rd;
        logic [4:0]       rn;
        logic [4:0]       rm;
        logic [4:0]       ra;
        logic             narrow;
        logic [IMM_W-1:0] imm;
        logic [1:0]       sk;
        logic [5:0]       sa;
        logic [3:0]       cc;
    } dec_t;

    // result transfer layout, last field in the lowest bits
    typedef struct packed {
        logic [3:0]        cc;
        logic [5:0]        sa;
        logic [1:0]        sk;
        logic [IMM_W-1:0]  imm;
        logic              narrow;
        logic [4:0]        ra;
        logic [4:0]        rm;
        logic [4:0]        rn;
        logic [4:0]        rd;
        logic [5:0]        mn;
        logic [ADDR_W-1:0] addr;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

FILE: sv/a64_instruction_subset_decoder_top.sv
// A64 instruction subset decoder: one instruction word in, one decoded result out per
// transfer. Each word passes an input register, the decoder logic and an output register,
// before its result is offered on m_tvalid, and a new word can be taken every cycle; the only
// limit on rate is the result side holding m_tready low. The address of each word is
// base_address plus four per word, and the word marked by s_tlast makes the next word start
// again at the base. Writing base_address also restarts the address count at the new base;
// the user must write it only while no word is in flight, which the block does not enforce.
// Unrecognized words give mnemonic 0 with the raw word in the immediate field.
module a64_instruction_subset_decoder_top (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: base_address
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data,
    // instruction words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // insn_word
    input  logic         s_tlast,   // final_word
    // decoded results
    output logic         m_tvalid,
    input  logic         m_tready,
    // insn_address[63:0], mnemonic[69:64], dest_reg[74:70], first_src_reg[79:75],
    // second_src_reg[84:80], third_src_reg[89:85], narrow_regs[90], immediate[123:91],
    // shift_kind[125:124], shift_amount[131:126], condition_code[135:132]
    output logic [135:0] m_tdata
);
    import a64d_pkg::*;

    logic              accept;
    logic              out_ready;
    logic              stage_move;
    logic [ADDR_W-1:0] cur_addr;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [WORD_W-1:0] word_reg;
    logic [ADDR_W-1:0] word_addr_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;

    dec_t              dec;

    assign cfg_ready  = 1'b1;
    assign out_ready  = !out_valid_reg || m_tready;
    assign s_tready   = !in_valid_reg || out_ready;
    assign accept     = s_tvalid && s_tready;
    assign stage_move = in_valid_reg && out_ready;

    a64d_addr_ctr u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .base_we   (cfg_valid && cfg_ready),
        .base_data (cfg_data),
        .advance   (accept),
        .last      (s_tlast),
        .cur_addr  (cur_addr)
    );

    a64d_decode u_dec (
        .insn (word_reg),
        .dec  (dec)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (out_ready) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg      <= s_tdata;
            word_addr_reg <= cur_addr;
        end
        if (stage_move) begin
            out_reg.addr   <= word_addr_reg;
            out_reg.mn     <= dec.mn;
            out_reg.rd     <= dec.rd;
            out_reg.rn     <= dec.rn;
            out_reg.rm     <= dec.rm;
            out_reg.ra     <= dec.ra;
            out_reg.narrow <= dec.narrow;
            out_reg.imm    <= dec.imm;
            out_reg.sk     <= dec.sk;
            out_reg.sa     <= dec.sa;
            out_reg.cc     <= dec.cc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = RESULT_W'(out_reg);

endmodule

FILE: sv/a64d_decode.sv
// combinational decode of one a64 instruction word into mnemonic and operands
module a64d_decode (
    input  logic [a64d_pkg::WORD_W-1:0] insn,
    output a64d_pkg::dec_t              dec
);
    import a64d_pkg::*;

    localparam logic [31:0] PAT_B       = 32'h14000000;
    localparam logic [31:0] PAT_BL      = 32'h94000000;
    localparam logic [31:0] PAT_BR      = 32'hD61F0000;
    localparam logic [31:0] PAT_BLR     = 32'hD63F0000;
    localparam logic [31:0] PAT_RET     = 32'hD65F0000;
    localparam logic [31:0] PAT_NOP     = 32'hD503201F;
    localparam logic [31:0] PAT_HLT     = 32'hD4400000;
    localparam logic [31:0] PAT_CB      = 32'h34000000;
    localparam logic [31:0] PAT_TB      = 32'h36000000;
    localparam logic [31:0] PAT_LDST    = 32'h39000000;
    localparam logic [31:0] PAT_PAIR    = 32'h29000000;
    localparam logic [31:0] PAT_PAIR_LD = 32'h29400000;
    localparam logic [31:0] PAT_PAIR_ST = 32'hA9000000;
    localparam logic [31:0] PAT_ADDI    = 32'h11000000;
    localparam logic [31:0] PAT_MOVW    = 32'h12800000;
    localparam logic [31:0] PAT_ADR     = 32'h10000000;
    localparam logic [31:0] PAT_ADDR    = 32'h0B000000;
    localparam logic [31:0] PAT_ADC     = 32'h1A000000;
    localparam logic [31:0] PAT_MUL     = 32'h1B000000;
    localparam logic [31:0] PAT_ONESRC  = 32'h5AC00000;
    localparam logic [31:0] PAT_LOGIC   = 32'h0A000000;
    localparam logic [31:0] PAT_CSEL    = 32'h1A800000;

    logic [31:0]      w;
    logic             sf;
    logic [1:0]       size;
    logic [1:0]       ldst_opc;
    logic             ldst_ok;
    logic             movw_ok;
    logic             addr_ok;
    logic             logic_ok;
    logic             onesrc_ok;
    logic [IMM_W-1:0] imm_pair;
    logic [20:0]      adr_raw;
    logic [IMM_W-1:0] imm_adr;
    logic [5:0]       onesrc_mn;

    assign w        = insn;
    assign sf       = w[31];
    assign size     = w[31:30];
    assign ldst_opc = w[23:22];
    assign ldst_ok  = (ldst_opc == 2'd0) || (ldst_opc == 2'd1) ||
                      (ldst_opc == 2'd2 && size == 2'd2);
    assign movw_ok  = !(w[30:29] == 2'd1 || (!sf && w[22]));
    assign addr_ok  = !(w[23:22] == 2'd3 || (!sf && w[15]));
    assign logic_ok = !(w[30:29] == 2'd3 || (!sf && w[15]));
    assign imm_pair = {{(IMM_W-7){w[21]}}, w[21:15]};
    assign adr_raw  = {w[23:5], w[30:29]};
    assign imm_adr  = {{(IMM_W-21){adr_raw[20]}}, adr_raw};

    always_comb begin
        onesrc_ok = 1'b1;
        onesrc_mn = MN_NONE;
        case (w[15:10])
            6'd0: onesrc_mn = MN_RBIT;
            6'd1: onesrc_mn = MN_REV16;
            6'd2: onesrc_mn = sf ? MN_REV32 : MN_REV;
            6'd3: begin
                onesrc_mn = MN_REV;
                onesrc_ok = sf;
            end
            6'd4: onesrc_mn = MN_CLZ;
            6'd5: onesrc_mn = MN_CLS;
            default: onesrc_ok = 1'b0;
        endcase
    end

    always_comb begin
        dec = '0;
        if ((w & 32'hFFFFFC1F) == PAT_BR) begin
            dec.mn = MN_BR;
            dec.rn = w[9:5];
        end else if ((w & 32'hFFFFFC1F) == PAT_BLR) begin
            dec.mn = MN_BLR;
            dec.rn = w[9:5];
        end else if ((w & 32'hFFFFFC1F) == PAT_RET) begin
            dec.mn = MN_RET;
            dec.rn = w[9:5];
        end else if (w == PAT_NOP) begin
            dec.mn = MN_NOP;
        end else if ((w & 32'hFFE0001F) == PAT_HLT) begin
            dec.mn  = MN_HLT;
            dec.imm = IMM_W'(w[20:5]);
        end else if ((w & 32'hFC000000) == PAT_B || (w & 32'hFC000000) == PAT_BL) begin
            dec.mn  = ((w & 32'hFC000000) == PAT_BL) ? MN_BL : MN_B;
            dec.imm = {{(IMM_W-28){w[25]}}, w[25:0], 2'b00};
        end else if ((w & 32'h7E000000) == PAT_CB) begin
            dec.mn     = w[24] ? MN_CBNZ : MN_CBZ;
            dec.rd     = w[4:0];
            dec.narrow = ~sf;
            dec.imm    = {{(IMM_W-21){w[23]}}, w[23:5], 2'b00};
        end else if ((w & 32'h7E000000) == PAT_TB) begin
            dec.mn     = w[24] ? MN_TBNZ : MN_TBZ;
            dec.rd     = w[4:0];
            dec.narrow = ~sf;
            dec.sa     = {w[31], w[23:19]};
            dec.imm    = {{(IMM_W-16){w[18]}}, w[18:5], 2'b00};
        end else if ((w & 32'h3F000000) == PAT_LDST && ldst_ok) begin
            dec.rd  = w[4:0];
            dec.rn  = w[9:5];
            dec.imm = IMM_W'(w[21:10]) << size;
            if (ldst_opc == 2'd2) begin
                dec.mn     = MN_LDRSW;
                dec.narrow = 1'b0;
            end else begin
                dec.narrow = (size != 2'd3);
                case (size)
                    2'd0:    dec.mn = ldst_opc[0] ? MN_LDRB : MN_STRB;
                    2'd1:    dec.mn = ldst_opc[0] ? MN_LDRH : MN_STRH;
                    default: dec.mn = ldst_opc[0] ? MN_LDR : MN_STR;
                endcase
            end
        end else if ((w & 32'h7FC00000) == PAT_PAIR ||
                     (w & 32'h7FC00000) == PAT_PAIR_LD) begin
            // 64-bit pairs (PAT_PAIR_ST form) scale by 8, 32-bit by 4
            dec.mn     = w[22] ? MN_LDP : MN_STP;
            dec.narrow = ~sf;
            dec.rd     = w[4:0];
            dec.rn     = w[9:5];
            dec.rm     = w[14:10];
            dec.imm    = ((w & 32'hFFC00000) == PAT_PAIR_ST || sf) ?
                         (imm_pair << 3) : (imm_pair << 2);
        end else if ((w & 32'h1F800000) == PAT_ADDI) begin
            dec.rd     = w[4:0];
            dec.rn     = w[9:5];
            dec.narrow = ~sf;
            dec.imm    = w[22] ? (IMM_W'(w[21:10]) << 12) : IMM_W'(w[21:10]);
            if (w[29] && w[4:0] == REG_ZR) begin
                dec.mn = w[30] ? MN_CMP : MN_CMN;
            end else begin
                dec.mn = MN_ADD + {4'd0, w[30], w[29]};
            end
        end else if ((w & 32'h1F800000) == PAT_MOVW && movw_ok) begin
            dec.rd     = w[4:0];
            dec.narrow = ~sf;
            dec.imm    = IMM_W'(w[20:5]);
            dec.sa     = {w[22:21], 4'd0};
            case (w[30:29])
                2'd0:    dec.mn = MN_MOVN;
                2'd2:    dec.mn = MN_MOVZ;
                default: dec.mn = MN_MOVK;
            endcase
        end else if ((w & 32'h1F000000) == PAT_ADR) begin
            dec.rd  = w[4:0];
            dec.mn  = sf ? MN_ADRP : MN_ADR;
            dec.imm = sf ? (imm_adr << 12) : imm_adr;
        end else if ((w & 32'h1F200000) == PAT_ADDR && addr_ok) begin
            dec.rd     = w[4:0];
            dec.rn     = w[9:5];
            dec.rm     = w[20:16];
            dec.narrow = ~sf;
            dec.sk     = w[23:22];
            dec.sa     = w[15:10];
            if (w[29] && w[4:0] == REG_ZR) begin
                dec.mn = w[30] ? MN_CMP : MN_CMN;
            end else if (w[30] && !w[29] && w[9:5] == REG_ZR) begin
                dec.mn = MN_NEG;
            end else begin
                dec.mn = MN_ADD + {4'd0, w[30], w[29]};
            end
        end else if ((w & 32'h1FE0FC00) == PAT_ADC) begin
            dec.rd     = w[4:0];
            dec.rn     = w[9:5];
            dec.rm     = w[20:16];
            dec.narrow = ~sf;
            dec.mn     = MN_ADC + {4'd0, w[30:29]};
        end else if ((w & 32'h7FE00000) == PAT_MUL) begin
            dec.rd     = w[4:0];
            dec.rn     = w[9:5];
            dec.rm     = w[20:16];
            dec.ra     = w[14:10];
            dec.narrow = ~sf;
            if (w[15]) begin
                dec.mn = MN_MSUB;
            end else begin
                dec.mn = (w[14:10] == REG_ZR) ? MN_MUL : MN_MADD;
            end
        end else if ((w & 32'h7FFF0000) == PAT_ONESRC && onesrc_ok) begin
            dec.mn     = onesrc_mn;
            dec.rd     = w[4:0];
            dec.rn     = w[9:5];
            dec.narrow = ~sf;
        end else if ((w & 32'h1F000000) == PAT_LOGIC && logic_ok) begin
            dec.rd     = w[4:0];
            dec.rn     = w[9:5];
            dec.rm     = w[20:16];
            dec.narrow = ~sf;
            dec.sk     = w[23:22];
            dec.sa     = w[15:10];
            // orr with zero register, no shift, is the mov alias
            if (w[30:29] == 2'd1 && !w[21] && w[23:22] == 2'd0 && w[15:10] == 6'd0 &&
                w[9:5] == REG_ZR) begin
                dec.mn = MN_MOV;
            end else begin
                dec.mn = MN_AND + {3'd0, w[30:29], w[21]};
            end
        end else if ((w & 32'h7FE00800) == PAT_CSEL) begin
            dec.rd     = w[4:0];
            dec.rn     = w[9:5];
            dec.rm     = w[20:16];
            dec.narrow = ~sf;
            dec.cc     = w[15:12];
            if (!w[10]) begin
                dec.mn = MN_CSEL;
            end else if (w[9:5] == REG_ZR && w[20:16] == REG_ZR && w[15:13] != 3'd7) begin
                dec.mn = MN_CSET;
                dec.cc = w[15:12] ^ 4'd1;
            end else begin
                dec.mn = MN_CSINC;
            end
        end else begin
            dec.imm = IMM_W'(w);
        end
    end

endmodule

FILE: sv/a64d_addr_ctr.sv
// instruction address counter, reloaded from the base register
module a64d_addr_ctr (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        base_we,
    input  logic [a64d_pkg::ADDR_W-1:0] base_data,
    input  logic                        advance,
    input  logic                        last,
    output logic [a64d_pkg::ADDR_W-1:0] cur_addr
);
    import a64d_pkg::*;

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    always_comb begin
        base_next = base_reg;
        addr_next = addr_reg;
        if (base_we) begin
            base_next = base_data;
            addr_next = base_data;
        end else if (advance) begin
            addr_next = last ? base_reg : addr_reg + ADDR_W'(4);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            addr_reg <= '0;
        end else begin
            base_reg <= base_next;
            addr_reg <= addr_next;
        end
    end

    assign cur_addr = addr_reg;

endmodule

FILE: sv/a64d_checker.sv
// port-level checks of the decoder, attached to the top level by bind
`include "assert_macros.svh"

module a64d_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);
    import a64d_pkg::*;

    result_t res;
    logic    s_xfer;
    logic    unrec_clean;

    assign res         = m_tdata;
    assign s_xfer      = s_tvalid && s_tready;
    assign unrec_clean = (res.rd == '0) && (res.rn == '0) && (res.rm == '0) &&
                         (res.ra == '0) && !res.narrow && !res.imm[IMM_W-1] &&
                         (res.sk == '0) && (res.sa == '0) && (res.cc == '0);

    // a stalled result stays offered
    `A64D_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // every accepted word has a result on offer once it has passed the input and output registers
    `A64D_ASSERT_LATER2(a_result_due, aclk, aresetn, s_xfer, m_tvalid)
    // mnemonic never leaves the defined range
    `A64D_ASSERT_NOW(a_mn_range, aclk, aresetn, m_tvalid, res.mn <= MN_LAST)
    // unrecognized words carry only the raw word
    `A64D_ASSERT_NOW(a_unrec_clean, aclk, aresetn, m_tvalid && res.mn == MN_NONE, unrec_clean)
    // compare aliases always target the zero register
    `A64D_ASSERT_NOW(a_cmp_zr, aclk, aresetn,
        m_tvalid && (res.mn == MN_CMP || res.mn == MN_CMN), res.rd == REG_ZR)

endmodule

bind a64_instruction_subset_decoder_top a64d_checker u_a64d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
